[rtl/jfs_pkg.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil package
// Register indexes, configuration widths and reset values for the
// stencil top-level module.
// ----------------------------------------------------------------------------
package jfs_pkg;

    localparam int CFG_BITS   = 11;
    localparam int GRID_RESET = 1024;

    typedef enum logic
    {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

[rtl/jfs_line_buf.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil line buffers
// Two synchronous line memories holding the previous two rows, each with one
// write port and one registered read port, plus same-address forwarding.
// ----------------------------------------------------------------------------
module jfs_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_BITS-1:0]         one_wdata,
    input  logic [DATA_BITS-1:0]         two_wdata,
    input  logic [$clog2(DEPTH)-1:0]     one_raddr,
    input  logic [$clog2(DEPTH)-1:0]     two_raddr,
    output logic [DATA_BITS-1:0]         one_q,
    output logic [DATA_BITS-1:0]         two_q
);

    logic [DATA_BITS-1:0] one_mem [DEPTH];
    logic [DATA_BITS-1:0] two_mem [DEPTH];

    logic [DATA_BITS-1:0] one_rd_reg;
    logic [DATA_BITS-1:0] two_rd_reg;
    logic [DATA_BITS-1:0] one_fwd_data_reg;
    logic [DATA_BITS-1:0] two_fwd_data_reg;
    logic                 one_fwd_reg;
    logic                 two_fwd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            one_mem[wr_addr] <= one_wdata;
            two_mem[wr_addr] <= two_wdata;
            one_rd_reg       <= one_mem[one_raddr];
            two_rd_reg       <= two_mem[two_raddr];
            one_fwd_data_reg <= one_wdata;
            two_fwd_data_reg <= two_wdata;
        end
    end

    // A read of the entry written on the same edge must see the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_fwd_reg <= 1'b0;
            two_fwd_reg <= 1'b0;
        end
        else if (en)
        begin
            one_fwd_reg <= (one_raddr == wr_addr);
            two_fwd_reg <= (two_raddr == wr_addr);
        end
    end

    assign one_q = one_fwd_reg ? one_fwd_data_reg : one_rd_reg;
    assign two_q = two_fwd_reg ? two_fwd_data_reg : two_rd_reg;

endmodule

[rtl/jfs_out_queue.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil result queue
// Two-entry output buffer that lets the stencil keep taking requests while a
// finished result waits to be taken downstream.
// ----------------------------------------------------------------------------
module jfs_out_queue #(
    parameter int DATA_BITS = 56
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output logic [DATA_BITS-1:0] pop_data
);

    logic [DATA_BITS-1:0] entry_mem [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 pop;

    assign pop       = pop_valid && pop_ready;
    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/jacobi_four_neighbor_stencil.sv]
// A result enters the result queue with the request carrying its lower neighbour.
// One request per cycle while the queue has room, set by each memory's single read port.
// The two-entry result queue keeps requests flowing while one result is stalled.
// Reset clears the row and column counters and sets width and height to 1024,
// capped at the maximum; the line memories are not cleared.
// ----------------------------------------------------------------------------
// Jacobi four-neighbour stencil
// Streams a raster-ordered grid through two line memories and emits the sum
// of the four neighbours of every interior point as an exact Q16.18 mean.
// ----------------------------------------------------------------------------
module jacobi_four_neighbor_stencil #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [jfs_pkg::CFG_BITS-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS+1:0]       average,
    output logic [$clog2(MAX_HEIGHT)-1:0]       out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
    output logic                                frame_last
);

    import jfs_pkg::*;

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int AVG_BITS  = SAMPLE_BITS + 2;
    localparam int RES_BITS  = AVG_BITS + ROW_BITS + COL_BITS + 1;
    localparam int RESET_W   = (GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET;
    localparam int RESET_H   = (GRID_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_RESET;

    logic [COL_BITS-1:0]    last_col_reg;
    logic [COL_BITS-1:0]    last_col_next;
    logic [ROW_BITS-1:0]    last_row_reg;
    logic [ROW_BITS-1:0]    last_row_next;
    logic [COL_BITS-1:0]    col_count_reg;
    logic [COL_BITS-1:0]    col_count_next;
    logic [ROW_BITS-1:0]    row_count_reg;
    logic [ROW_BITS-1:0]    row_count_next;

    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] left_next;
    logic [SAMPLE_BITS-1:0] centre_reg;
    logic [SAMPLE_BITS-1:0] centre_next;
    logic [SAMPLE_BITS-1:0] first_reg;
    logic [SAMPLE_BITS-1:0] first_next;

    logic                   accept;
    logic                   col_wrap;
    logic                   row_wrap;
    logic                   interior;
    logic                   last_point;
    logic [COL_BITS:0]      col_inc;
    logic [COL_BITS:0]      right_addr;
    logic [COL_BITS-1:0]    one_raddr;
    logic [COL_BITS-1:0]    two_raddr;
    logic [SAMPLE_BITS-1:0] right_q;
    logic [SAMPLE_BITS-1:0] up_q;
    logic signed [AVG_BITS-1:0] sum_lu;
    logic signed [AVG_BITS-1:0] sum_rd;
    logic signed [AVG_BITS-1:0] sum;
    logic [RES_BITS-1:0]    push_data;
    logic [RES_BITS-1:0]    pop_data;
    logic                   queue_full;

    // Configuration: store the last column and last row of the effective grid.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            last_col_next = '0;
            last_row_next = '0;
        end
        else
        begin
            if (32'(cfg_data) > MAX_WIDTH)
            begin
                last_col_next = COL_BITS'(MAX_WIDTH - 1);
            end
            else
            begin
                last_col_next = COL_BITS'(cfg_data - 1'b1);
            end
            if (32'(cfg_data) > MAX_HEIGHT)
            begin
                last_row_next = ROW_BITS'(MAX_HEIGHT - 1);
            end
            else
            begin
                last_row_next = ROW_BITS'(cfg_data - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= COL_BITS'(RESET_W - 1);
            last_row_reg <= ROW_BITS'(RESET_H - 1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  last_col_reg <= last_col_next;
                REG_GRID_HEIGHT: last_row_reg <= last_row_next;
                default:         last_col_reg <= last_col_reg;
            endcase
        end
    end

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign col_wrap   = (col_count_reg >= last_col_reg);
    assign row_wrap   = (row_count_reg >= last_row_reg);
    assign col_inc    = {1'b0, col_count_reg} + 1'b1;
    assign interior   = (row_count_reg >= ROW_BITS'(2)) && (row_count_reg <= last_row_reg) &&
                        (col_count_reg != '0) && (col_count_reg < last_col_reg);
    assign last_point = (row_count_reg == last_row_reg) &&
                        (col_inc == {1'b0, last_col_reg});

    always_comb
    begin
        if (col_wrap)
        begin
            col_count_next = '0;
            row_count_next = row_wrap ? '0 : row_count_reg + 1'b1;
        end
        else
        begin
            col_count_next = col_inc[COL_BITS-1:0];
            row_count_next = row_count_reg;
        end
    end

    // Prefetch for the next position: the upper row at its right-hand column and
    // the row above that at its own column.
    always_comb
    begin
        right_addr = {1'b0, col_count_next} + 1'b1;
        if (right_addr >= (COL_BITS + 1)'(MAX_WIDTH))
        begin
            one_raddr = '0;
        end
        else
        begin
            one_raddr = right_addr[COL_BITS-1:0];
        end
        two_raddr = col_count_next;
    end

    // The window keeps the upper row at the current and left-hand columns, and
    // the upper row at column zero for the start of the next row.
    always_comb
    begin
        first_next  = (col_count_reg == '0) ? sample : first_reg;
        centre_next = col_wrap ? first_next : right_q;
        left_next   = centre_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg   <= left_next;
            centre_reg <= centre_next;
            first_reg  <= first_next;
        end
    end

    jfs_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (SAMPLE_BITS)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .wr_addr   (col_count_reg),
        .one_wdata (sample),
        .two_wdata (centre_reg),
        .one_raddr (one_raddr),
        .two_raddr (two_raddr),
        .one_q     (right_q),
        .two_q     (up_q)
    );

    assign sum_lu = AVG_BITS'($signed(left_reg)) + AVG_BITS'($signed(up_q));
    assign sum_rd = AVG_BITS'($signed(right_q)) + AVG_BITS'(sample);
    assign sum    = sum_lu + sum_rd;

    assign push_data = {sum, row_count_reg - 1'b1, col_count_reg, last_point};

    jfs_out_queue #(
        .DATA_BITS (RES_BITS)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && interior),
        .push_data (push_data),
        .full      (queue_full),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (pop_data)
    );

    assign average    = pop_data[RES_BITS-1 -: AVG_BITS];
    assign out_row    = pop_data[COL_BITS+ROW_BITS -: ROW_BITS];
    assign out_col    = pop_data[COL_BITS -: COL_BITS];
    assign frame_last = pop_data[0];

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready) || $past(out_valid && !out_ready)
    ) else $error("input stalled without a waiting result");

    a_interior_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && interior) |=> out_valid
    ) else $error("interior point produced no result");

    a_frame_wraps: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && col_wrap && row_wrap) |=> (row_count_reg == '0) && (col_count_reg == '0)
    ) else $error("counters did not return to zero at the end of a frame");
`endif

endmodule
